FILE: src/plid_pkg.sv
package plid_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > 5) ? CNT_W : 5;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_DELETE = 3'd1;
	localparam logic [2:0] OP_PUSH   = 3'd2;
	localparam logic [2:0] OP_POP    = 3'd3;
	localparam logic [2:0] OP_INJECT = 3'd4;
	localparam logic [2:0] OP_EJECT  = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [4:0]         position;
		logic signed [31:0] value;
	} req_item_t;

	typedef struct packed {
		logic signed [31:0] removed_value;
		logic [1:0]         status;
		logic [4:0]         count_after;
	} rsp_item_t;

	// broadcast to every cell in the row
	typedef struct packed {
		logic               ins;
		logic               del;
		logic [CMP_W-1:0]   pos;
		logic signed [31:0] value;
	} cell_cmd_t;

endpackage

FILE: src/plid_cell.sv
module plid_cell (
	input  logic                      clk,
	input  plid_pkg::cell_cmd_t       cmd,
	input  logic [plid_pkg::CMP_W-1:0] idx,
	input  logic signed [31:0]        left_entry,
	input  logic signed [31:0]        right_entry,
	output logic signed [31:0]        entry,
	output logic signed [31:0]        pick
);
	import plid_pkg::*;

	logic signed [31:0] entry_q;
	logic               at_pos;
	logic               past_pos;

	assign at_pos   = (idx == cmd.pos);
	assign past_pos = (idx > cmd.pos);

	// insert: cells behind the position take the left neighbor, the position takes the key;
	// delete: the position and everything behind it take the right neighbor
	always_ff @(posedge clk) begin
		priority if (cmd.ins && past_pos) begin
			entry_q <= left_entry;
		end else if (cmd.ins && at_pos) begin
			entry_q <= cmd.value;
		end else if (cmd.del && (at_pos || past_pos)) begin
			entry_q <= right_entry;
		end else begin
			entry_q <= entry_q;
		end
	end

	assign entry = entry_q;
	assign pick  = at_pos ? entry_q : 32'sd0;

endmodule

FILE: src/positional_list_deque.sv
// Positional list deque: up to CAPACITY signed 32-bit keys held in a row of cells.
// Request channel (req_valid / req_stall / req): opcode, position, value. A transaction
// completes on a rising edge with req_valid high and req_stall low.
// Response channel (rsp_valid / rsp_stall / rsp): one response per request carrying the
// removed key (zero unless a delete, pop or eject succeeded), a status and the entry count
// after the request.
// The response is registered at the edge that takes the request.
// One request is taken per cycle while no response waits under rsp_stall; every cell shifts
// or holds in parallel in that same cycle, so the row of cells sets the rate.
// While a response waits under rsp_stall, req_stall is high and no request is taken; the
// waiting response holds steady. Taking the response and a new request in one cycle is fine.
// Reset empties the list (count zero) and drops any pending response; the cells themselves
// are not cleared, since only entries below the count are ever read.
module positional_list_deque (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  plid_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output plid_pkg::rsp_item_t rsp
);
	import plid_pkg::*;

	logic [CNT_W-1:0]   count_q;
	logic               rsp_valid_q;
	rsp_item_t          rsp_q;

	logic               take;
	logic               is_ins;
	logic               is_del;
	logic [CMP_W-1:0]   cnt_x;
	logic [CMP_W-1:0]   pos_x;
	logic [CMP_W-1:0]   ins_pos;
	logic [CMP_W-1:0]   del_pos;
	logic               ins_range_err;
	logic               full;
	logic               del_range_err;
	logic               ins_ok;
	logic               del_ok;
	logic [1:0]         status;
	logic [CNT_W-1:0]   count_next;
	logic signed [31:0] removed;
	cell_cmd_t          cmd;

	logic signed [31:0] entries [CAPACITY];
	logic signed [31:0] picks   [CAPACITY];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign take      = req_valid && !req_stall;

	assign cnt_x = CMP_W'(count_q);
	assign pos_x = CMP_W'(req.position);

	always_comb begin
		is_ins  = 1'b0;
		is_del  = 1'b0;
		ins_pos = pos_x;
		del_pos = pos_x;
		unique case (req.opcode)
			OP_INSERT: begin
				is_ins = 1'b1;
			end
			OP_DELETE: begin
				is_del = 1'b1;
			end
			OP_PUSH: begin
				is_ins  = 1'b1;
				ins_pos = '0;
			end
			OP_POP: begin
				is_del  = 1'b1;
				del_pos = '0;
			end
			OP_INJECT: begin
				is_ins  = 1'b1;
				ins_pos = cnt_x;
			end
			OP_EJECT: begin
				is_del  = 1'b1;
				del_pos = cnt_x - CMP_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign ins_range_err = ins_pos > cnt_x;
	assign full          = (count_q == CNT_W'(CAPACITY));
	// an empty list wraps the eject position, which still lands at or past the count
	assign del_range_err = (count_q == '0) || (del_pos >= cnt_x);
	assign ins_ok        = is_ins && !ins_range_err && !full;
	assign del_ok        = is_del && !del_range_err;

	always_comb begin
		priority if (ins_ok || del_ok) begin
			status = ST_OK;
		end else if (is_ins && !ins_range_err) begin
			status = ST_FULL;
		end else begin
			status = ST_RANGE;
		end
	end

	always_comb begin
		priority if (ins_ok) begin
			count_next = count_q + CNT_W'(1);
		end else if (del_ok) begin
			count_next = count_q - CNT_W'(1);
		end else begin
			count_next = count_q;
		end
	end

	assign cmd.ins   = take && ins_ok;
	assign cmd.del   = take && del_ok;
	assign cmd.pos   = is_ins ? ins_pos : del_pos;
	assign cmd.value = req.value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		plid_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.idx         (CMP_W'(i)),
			.left_entry  ((i == 0) ? 32'sd0 : entries[(i == 0) ? 0 : i - 1]),
			.right_entry ((i == CAPACITY - 1) ? 32'sd0
			              : entries[(i == CAPACITY - 1) ? i : i + 1]),
			.entry       (entries[i]),
			.pick        (picks[i])
		);
	end

	// only the cell at the delete position contributes
	always_comb begin
		removed = 32'sd0;
		for (int i = 0; i < CAPACITY; i++) begin
			removed = removed | picks[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q.removed_value <= del_ok ? removed : 32'sd0;
			rsp_q.status        <= status;
			rsp_q.count_after   <= 5'(count_next);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_take_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> rsp_valid)
		else $error("accepted request produced no response");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.count_after == 5'(CAPACITY))
		else $error("full status with count below capacity");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.removed_value == 32'sd0)
		else $error("error response carries a removed key");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(count_q))
		else $error("entry count moved without a request");

endmodule
